/* hdl/bce_pkg.sv */
// Package with shared types, constants and tables of the Bezier curve evaluator.
package bce_pkg;

    localparam int MaxPoints  = 16;
    localparam int SweepSteps = 50;
    localparam int IdxW       = $clog2(MaxPoints);
    localparam int CntW       = 5;
    localparam int StepW      = $clog2(SweepSteps);
    localparam int FracW      = StepW + 1;
    localparam logic [16:0] OneQ16 = 17'h10000;

    // Sweep parameter increment: whole part and remainder of 65536 / SweepSteps.
    localparam logic [16:0]      StepInt  = 17'(65536 / SweepSteps);
    localparam logic [FracW-1:0] StepRem  = FracW'(65536 % SweepSteps);
    localparam logic [FracW-1:0] FracWrap = FracW'(SweepSteps);

    // Input mode codes.
    localparam logic [1:0] ModeLoad  = 2'd0;
    localparam logic [1:0] ModeEval  = 2'd1;
    localparam logic [1:0] ModeSweep = 2'd2;

    // One command handed from the front part to the back part.
    typedef struct packed {
        logic        sweep;
        logic [16:0] t;
    } cmd_t;

    // Back part sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POW,
        ST_WEIGHT,
        ST_BINOM,
        ST_ACC,
        ST_OUT
    } state_t;

    // Binomial coefficients C(d, i) for d below MaxPoints, indexed [d][i].
    typedef logic [MaxPoints-1:0][MaxPoints-1:0][15:0] binom_tab_t;

    // Pascal's triangle, built once at elaboration.
    function automatic binom_tab_t build_binom();
        binom_tab_t tab;
        tab = '0;
        for (int d = 0; d < MaxPoints; d++) begin
            tab[d][0] = 16'd1;
            for (int i = 1; i <= d; i++) begin
                tab[d][i] = tab[d-1][i-1] + tab[d-1][i];
            end
        end
        return tab;
    endfunction

    localparam binom_tab_t BinomTab = build_binom();

endpackage

/* hdl/bce_front.sv */
// Front part: takes items, writes control points, queues evaluation commands.
module bce_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_mode,
    input  logic [3:0]        s_point_index,
    input  logic signed [31:0] s_coord_x,
    input  logic signed [31:0] s_coord_y,
    input  logic signed [31:0] s_coord_z,
    input  logic [16:0]       s_param_t,
    output logic              wr_en,
    output logic [bce_pkg::IdxW-1:0] wr_idx,
    output logic [95:0]       wr_data,
    output logic              q_valid,
    input  logic              q_ready,
    output bce_pkg::cmd_t     q_cmd
);
    // Two-entry queue of commands.
    bce_pkg::cmd_t q_mem_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    logic       push, pop, is_cmd, is_load;
    bce_pkg::cmd_t cmd_in;

    assign is_cmd  = (s_mode == bce_pkg::ModeEval) || (s_mode == bce_pkg::ModeSweep);
    assign is_load = (s_mode == bce_pkg::ModeLoad);
    // A load waits until no evaluation is queued or running, so it never overtakes one.
    assign s_ready = is_load ? ((cnt_reg == 2'd0) && q_ready) : (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready && is_cmd;
    assign pop     = q_valid && q_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = q_mem_reg[rp_reg];

    // Clamp the parameter to one.
    always_comb begin
        cmd_in.sweep = (s_mode == bce_pkg::ModeSweep);
        cmd_in.t     = (s_param_t > bce_pkg::OneQ16) ? bce_pkg::OneQ16 : s_param_t;
    end

    // Load writes go straight to the point store.
    assign wr_en   = s_valid && s_ready && is_load
                     && ({1'b0, s_point_index} < 5'(bce_pkg::MaxPoints));
    assign wr_idx  = bce_pkg::IdxW'(s_point_index);
    assign wr_data = {s_coord_z, s_coord_y, s_coord_x};

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + 2'd1;
        if (!push && pop) cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) q_mem_reg[wp_reg] <= cmd_in;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> !push) else $error("queue overflow");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (cnt_reg != 2'd0)) else $error("pop from empty queue");
`endif
endmodule

/* hdl/bce_back.sv */
// Back part: point store and sequential Bernstein evaluation.
module bce_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [bce_pkg::CntW-1:0] point_count,
    input  logic              wr_en,
    input  logic [bce_pkg::IdxW-1:0] wr_idx,
    input  logic [95:0]       wr_data,
    input  logic              q_valid,
    output logic              q_ready,
    input  bce_pkg::cmd_t     q_cmd,
    output logic              m_valid,
    input  logic              m_ready,
    output logic signed [31:0] m_out_x,
    output logic signed [31:0] m_out_y,
    output logic signed [31:0] m_out_z,
    output logic              m_last
);
    localparam int IW = bce_pkg::IdxW;

    // Control point memory: x, y, z side by side.
    logic [95:0] mem [bce_pkg::MaxPoints];
    logic [95:0] rd_reg;

    bce_pkg::state_t st_reg, st_next;
    logic        m_valid_reg;
    logic        sweep_reg;
    logic [16:0] t_reg, u_reg;
    logic [bce_pkg::StepW-1:0] j_reg;
    logic [bce_pkg::FracW-1:0] frac_reg;
    logic [IW-1:0] d_reg, i_reg, k_reg;
    logic        ph_reg;        // 0: power of t, 1: power of u
    logic [16:0] pt_reg, pu_reg;
    logic [33:0] prod_reg;
    logic [15:0] c_reg;
    logic signed [32:0] b_reg;
    logic signed [63:0] ax_reg, ay_reg, az_reg;
    logic [16:0] base, pcur;
    logic        pow_done;
    logic [IW-1:0] exp_cur;
    logic        out_fire;
    logic [bce_pkg::FracW-1:0] frac_sum, frac_step;
    logic        step_carry;
    logic [16:0] t_step;

    // Degree from the clamped point count.
    logic [IW-1:0] deg;
    always_comb begin
        if (point_count == '0) deg = '0;
        else if (point_count > bce_pkg::CntW'(bce_pkg::MaxPoints))
            deg = IW'(bce_pkg::MaxPoints - 1);
        else deg = IW'(point_count - 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_idx] <= wr_data;
        rd_reg <= mem[i_reg];
    end

    // One power step multiplies per cycle; exponent i for t, d-i for u.
    assign base     = ph_reg ? u_reg : t_reg;
    assign pcur     = ph_reg ? pu_reg : pt_reg;
    assign exp_cur  = ph_reg ? (d_reg - i_reg) : i_reg;
    assign pow_done = ph_reg && (k_reg == exp_cur);
    assign m_valid  = m_valid_reg;
    assign out_fire = m_valid && m_ready;
    assign q_ready  = (st_reg == bce_pkg::ST_IDLE);

    // Next sweep parameter: add the whole step and carry the remainder.
    assign frac_sum   = frac_reg + bce_pkg::StepRem;
    assign step_carry = (frac_sum >= bce_pkg::FracWrap);
    assign frac_step  = step_carry ? (frac_sum - bce_pkg::FracWrap) : frac_sum;
    assign t_step     = t_reg + bce_pkg::StepInt + 17'(step_carry);

    // Next state.
    always_comb begin
        st_next = st_reg;
        case (st_reg)
            bce_pkg::ST_IDLE:   if (q_valid) st_next = bce_pkg::ST_POW;
            bce_pkg::ST_POW:    if (pow_done) st_next = bce_pkg::ST_WEIGHT;
            bce_pkg::ST_WEIGHT: st_next = bce_pkg::ST_BINOM;
            bce_pkg::ST_BINOM:  st_next = bce_pkg::ST_ACC;
            bce_pkg::ST_ACC:    st_next = (i_reg == d_reg) ? bce_pkg::ST_OUT : bce_pkg::ST_POW;
            bce_pkg::ST_OUT: begin
                if (!m_valid) st_next = bce_pkg::ST_OUT;
                else if (out_fire) begin
                    if (!m_last) st_next = bce_pkg::ST_POW;
                    else st_next = bce_pkg::ST_IDLE;
                end
            end
            default: st_next = bce_pkg::ST_IDLE;
        endcase
    end

    // Saturating floor shift by 16 of an accumulator.
    function automatic logic [31:0] finish(input logic signed [63:0] a);
        logic signed [47:0] q;
        q = 48'(a >>> 16);
        if (q > 48'sh0000_7FFF_FFFF) return 32'h7FFF_FFFF;
        if (q < -48'sh0000_8000_0000) return 32'h8000_0000;
        return q[31:0];
    endfunction

    logic signed [63:0] mx, my, mz;
    assign mx = 64'($signed(rd_reg[31:0]))  * 64'(b_reg);
    assign my = 64'($signed(rd_reg[63:32])) * 64'(b_reg);
    assign mz = 64'($signed(rd_reg[95:64])) * 64'(b_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= bce_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (st_reg == bce_pkg::ST_ACC && i_reg == d_reg) m_valid_reg <= 1'b1;
            else if (out_fire) m_valid_reg <= 1'b0;
        end
    end

    // Datapath.
    always_ff @(posedge aclk) begin
        case (st_reg)
            bce_pkg::ST_IDLE: begin
                if (q_valid) begin
                    sweep_reg <= q_cmd.sweep;
                    j_reg     <= '0;
                    frac_reg  <= '0;
                    t_reg     <= q_cmd.sweep ? 17'd0 : q_cmd.t;
                    u_reg     <= bce_pkg::OneQ16 - (q_cmd.sweep ? 17'd0 : q_cmd.t);
                    d_reg     <= deg;
                    i_reg <= '0; k_reg <= '0; ph_reg <= 1'b0;
                    pt_reg <= bce_pkg::OneQ16; pu_reg <= bce_pkg::OneQ16;
                    ax_reg <= '0; ay_reg <= '0; az_reg <= '0;
                end
            end
            bce_pkg::ST_POW: begin
                if (k_reg == exp_cur) begin
                    ph_reg <= 1'b1;
                    k_reg  <= '0;
                end else begin
                    if (ph_reg) pu_reg <= 17'((34'(pcur) * 34'(base)) >> 16);
                    else        pt_reg <= 17'((34'(pcur) * 34'(base)) >> 16);
                    k_reg <= k_reg + 1'b1;
                end
            end
            bce_pkg::ST_WEIGHT: begin
                prod_reg <= 34'(pt_reg) * 34'(pu_reg);
                c_reg    <= bce_pkg::BinomTab[d_reg][i_reg];
            end
            bce_pkg::ST_BINOM: begin
                b_reg <= $signed(33'(c_reg) * 33'(17'(prod_reg >> 16)));
            end
            bce_pkg::ST_ACC: begin
                ax_reg <= ax_reg + mx; ay_reg <= ay_reg + my; az_reg <= az_reg + mz;
                pt_reg <= bce_pkg::OneQ16; pu_reg <= bce_pkg::OneQ16;
                ph_reg <= 1'b0; k_reg <= '0;
                if (i_reg != d_reg) i_reg <= i_reg + 1'b1;
            end
            bce_pkg::ST_OUT: begin
                if (out_fire && !m_last) begin
                    j_reg    <= j_reg + 1'b1;
                    frac_reg <= frac_step;
                    t_reg    <= t_step;
                    u_reg    <= bce_pkg::OneQ16 - t_step;
                    i_reg <= '0; k_reg <= '0; ph_reg <= 1'b0;
                    pt_reg <= bce_pkg::OneQ16; pu_reg <= bce_pkg::OneQ16;
                    ax_reg <= '0; ay_reg <= '0; az_reg <= '0;
                end
            end
            default: ;
        endcase
    end

    // Result outputs.
    always_comb begin
        m_out_x = finish(ax_reg);
        m_out_y = finish(ay_reg);
        m_out_z = finish(az_reg);
        m_last  = !sweep_reg || (j_reg == bce_pkg::StepW'(bce_pkg::SweepSteps - 1));
    end

`ifndef SYNTHESIS
    a_valid_in_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (st_reg == bce_pkg::ST_OUT)) else $error("result outside output state");
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg != bce_pkg::ST_IDLE) |-> (i_reg <= d_reg)) else $error("point index past degree");
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg != bce_pkg::ST_IDLE) |-> (j_reg < bce_pkg::StepW'(bce_pkg::SweepSteps)))
        else $error("sweep step out of range");
`endif
endmodule

/* hdl/bezier_curve_evaluator_top.sv */
// An evaluation item's result is worked out point by point through the power, weight,
// binomial and accumulate steps of the back part. A sweep gives its fifty points one
// after another; one item is worked at a time. Loads write the point store directly
// but wait until no evaluation is queued or running. Reset (aresetn, synchronous,
// active low) empties the queue, idles the sequencer, sets point_count to 4.
module bezier_curve_evaluator_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_mode,
    input  logic [3:0]        s_point_index,
    input  logic signed [31:0] s_coord_x,
    input  logic signed [31:0] s_coord_y,
    input  logic signed [31:0] s_coord_z,
    input  logic [16:0]       s_param_t,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [4:0]        cfg_data,
    output logic              m_valid,
    input  logic              m_ready,
    output logic signed [31:0] m_out_x,
    output logic signed [31:0] m_out_y,
    output logic signed [31:0] m_out_z,
    output logic              m_last
);
    logic [4:0] point_count_reg;
    logic        wr_en, q_valid, q_ready;
    logic [bce_pkg::IdxW-1:0] wr_idx;
    logic [95:0] wr_data;
    bce_pkg::cmd_t q_cmd;

    // Configuration register.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) point_count_reg <= 5'd4;
        else if (cfg_valid) point_count_reg <= cfg_data;
    end

    bce_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_mode, .s_point_index,
        .s_coord_x, .s_coord_y, .s_coord_z, .s_param_t,
        .wr_en, .wr_idx, .wr_data, .q_valid, .q_ready, .q_cmd
    );

    bce_back u_back (
        .aclk, .aresetn, .point_count(point_count_reg), .wr_en, .wr_idx, .wr_data,
        .q_valid, .q_ready, .q_cmd, .m_valid, .m_ready,
        .m_out_x, .m_out_y, .m_out_z, .m_last
    );
endmodule
